// ===== rtl/bmp_pkg.sv =====
`default_nettype none

package bmp_pkg;

   localparam int FRAC        = 32;
   localparam int KICK_FRAC   = 40;
   localparam int OPERAND_W   = 65;
   localparam int MAG_W       = 64;
   localparam int MUL_LATENCY = 5;
   localparam int ISQ_BITS    = 32;
   localparam int ISQ_LATENCY = ISQ_BITS + 2;
   localparam int DIV_STEPS   = 34;
   localparam int CSR_ADDR_W  = 2;

   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ELECTRIC_KICK = 2'd0,
      CSR_MAGNETIC_KICK = 2'd1
   } csr_index_type;

   // 1 + |v|^2 in unsigned Q.32 from three squared terms, clamped at all ones
   function automatic logic [63:0] norm_sum(input logic [63:0] t0, input logic [63:0] t1,
                                            input logic [63:0] t2);
      logic [65:0] s;
      s = {2'b00, ONE_Q32} + {2'b00, t0} + {2'b00, t1} + {2'b00, t2};
      return (s[65:64] != 2'b00) ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bmp_mul.sv =====
`default_nettype none

module bmp_mul import bmp_pkg::*; #(
   parameter int DATA_WIDTH = 48,
   parameter int SHIFT      = 32
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [OPERAND_W-1:0]  a_i,
   input  logic signed [OPERAND_W-1:0]  b_i,
   output logic signed [DATA_WIDTH-1:0] prod_o,
   output logic [63:0]                  sq_o
);

   localparam int W = DATA_WIDTH;
   localparam logic [128:0] ROUND_HALF = 129'd1 << (SHIFT - 1);
   localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

   logic signed [OPERAND_W-1:0] a_abs_in, b_abs_in;
   logic [MAG_W-1:0]  a_mag_ff, b_mag_ff;
   logic              neg1_ff, neg2_ff, neg3_ff;
   logic [63:0]       pp_ff [4];
   logic [127:0]      p_ff;
   logic [128:0]      rs_ff, rs_in;
   logic [63:0]       sq4_ff, sq5_ff;
   logic signed [W-1:0] prod_ff, prod_in;
   logic              fits;

   assign a_abs_in = a_i[OPERAND_W-1] ? -a_i : a_i;
   assign b_abs_in = b_i[OPERAND_W-1] ? -b_i : b_i;

   assign rs_in = ({1'b0, p_ff} ^ {129{neg3_ff}}) + {128'd0, neg3_ff} + ROUND_HALF;

   assign fits = (&rs_ff[128:SHIFT+W-1]) || ~(|rs_ff[128:SHIFT+W-1]);
   assign prod_in = fits ? rs_ff[SHIFT+W-1:SHIFT] : (rs_ff[128] ? MINW : MAXW);

   always_ff @(posedge clock) begin
      if (en) begin
         // magnitudes and product sign
         a_mag_ff <= a_abs_in[MAG_W-1:0];
         b_mag_ff <= b_abs_in[MAG_W-1:0];
         neg1_ff  <= a_i[OPERAND_W-1] ^ b_i[OPERAND_W-1];
         // 32 by 32 partial products
         pp_ff[0] <= {32'd0, a_mag_ff[31:0]}  * {32'd0, b_mag_ff[31:0]};
         pp_ff[1] <= {32'd0, a_mag_ff[31:0]}  * {32'd0, b_mag_ff[63:32]};
         pp_ff[2] <= {32'd0, a_mag_ff[63:32]} * {32'd0, b_mag_ff[31:0]};
         pp_ff[3] <= {32'd0, a_mag_ff[63:32]} * {32'd0, b_mag_ff[63:32]};
         neg2_ff  <= neg1_ff;
         p_ff     <= {64'd0, pp_ff[0]} + {32'd0, pp_ff[1], 32'd0}
                   + {32'd0, pp_ff[2], 32'd0} + {pp_ff[3], 64'd0};
         neg3_ff  <= neg2_ff;
         // signed value plus half an LSB; square clamps at 64 bits
         rs_ff    <= rs_in;
         sq4_ff   <= (|p_ff[127:96]) ? 64'hFFFF_FFFF_FFFF_FFFF : p_ff[95:32];
         prod_ff  <= prod_in;
         sq5_ff   <= sq4_ff;
      end
   end

   assign prod_o = prod_ff;
   assign sq_o   = sq5_ff;

endmodule

`default_nettype wire

// ===== rtl/bmp_isqrt.sv =====
`default_nettype none

module bmp_isqrt import bmp_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [2:0][63:0] t_i,
   output logic [32:0]      r_o
);

   localparam logic [127:0] LIMIT = 128'd1 << 96;

   logic [63:0] g_ff [0:ISQ_BITS];
   logic [96:0] p_ff [0:ISQ_BITS];
   logic [96:0] q_ff [0:ISQ_BITS];
   logic [31:0] r_ff [0:ISQ_BITS];
   logic [32:0] r_out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff[0] <= norm_sum(t_i[0], t_i[1], t_i[2]);
         p_ff[0] <= '0;
         q_ff[0] <= '0;
         r_ff[0] <= '0;
      end
   end

   // one result bit a stage; track r*r*g and r*g so no multiply is needed
   for (genvar n = 0; n < ISQ_BITS; n++) begin : g_step
      localparam int B = ISQ_BITS - 1 - n;
      logic [127:0] cand;
      logic         take;

      assign cand = {31'd0, p_ff[n]} + ({31'd0, q_ff[n]} << (B + 1))
                  + ({64'd0, g_ff[n]} << (2 * B));
      assign take = (cand <= LIMIT);

      always_ff @(posedge clock) begin
         if (en) begin
            g_ff[n+1] <= g_ff[n];
            if (take) begin
               p_ff[n+1] <= cand[96:0];
               q_ff[n+1] <= q_ff[n] + ({33'd0, g_ff[n]} << B);
               r_ff[n+1] <= r_ff[n] | (32'd1 << B);
            end else begin
               p_ff[n+1] <= p_ff[n];
               q_ff[n+1] <= q_ff[n];
               r_ff[n+1] <= r_ff[n];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_out_ff <= (g_ff[ISQ_BITS] <= ONE_Q32) ? {1'b1, 32'd0} : {1'b0, r_ff[ISQ_BITS]};
      end
   end

   assign r_o = r_out_ff;

endmodule

`default_nettype wire

// ===== rtl/boris_momentum_push_core.sv =====
// Throughput: one particle per cycle; a held result stalls the whole pipeline.
// The depth is set by three bit-serial units in a row (two 34-stage inverse
// square roots, one reciprocal of 1+|T|^2) and 5-stage multipliers between.
// Reset (synchronous, active high) clears all valid bits and both kick registers.
`default_nettype none

module boris_momentum_push_core import bmp_pkg::*; #(
   parameter int DATA_WIDTH = 48,
   localparam int REQ_TDATA_W = ((9 * DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_TDATA_W = ((3 * DATA_WIDTH + 33 + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // mom_x, mom_y, mom_z, efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // new_mom_x, new_mom_y, new_mom_z, inverse_gamma, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [DATA_WIDTH-1:0]  csr_wdata
);

   localparam int W = DATA_WIDTH;

   // stage at which each value is held, counted from the input transfer
   localparam int T_EH    = MUL_LATENCY;
   localparam int T_UM    = T_EH + 1;
   localparam int T_G1    = T_UM + MUL_LATENCY + ISQ_LATENCY;
   localparam int T_TV    = T_G1 + MUL_LATENCY;
   localparam int T_R1P   = T_TV + MUL_LATENCY;
   localparam int T_UP    = T_R1P + 2;
   localparam int T_D     = T_R1P + 1;
   localparam int T_TF    = T_D + DIV_STEPS;
   localparam int T_SV    = T_TF + MUL_LATENCY;
   localparam int T_R2P   = T_SV + MUL_LATENCY;
   localparam int T_UPL   = T_R2P + 2;
   localparam int T_NU    = T_UPL + 1;
   localparam int T_G2    = T_NU + MUL_LATENCY + ISQ_LATENCY;
   localparam int LATENCY = T_G2 + 1;

   localparam int MOM_DLY = T_EH;
   localparam int BM_DLY  = T_G1 - T_EH;
   localparam int UM_TAP1 = T_TV - T_UM;
   localparam int UM_TAP2 = T_R1P - T_UM;
   localparam int UM_DLY  = T_R2P - T_UM;
   localparam int TV_DLY  = T_TF - T_TV;
   localparam int UP_DLY  = T_SV - T_UP;
   localparam int EH_DLY  = T_UPL - T_EH;
   localparam int NU_DLY  = T_G2 - T_NU;

   typedef logic signed [W-1:0] word_type;
   typedef word_type [2:0]      vec_type;

   localparam logic signed [W+1:0] WMAX = {3'b000, {(W-1){1'b1}}};
   localparam logic signed [W+1:0] WMIN = {3'b111, {(W-1){1'b0}}};

   function automatic word_type sat_sum(input word_type a, input word_type b, input logic sub);
      logic signed [W+1:0] s;
      s = sub ? ({{2{a[W-1]}}, a} - {{2{b[W-1]}}, b}) : ({{2{a[W-1]}}, a} + {{2{b[W-1]}}, b});
      if (s > WMAX) return WMAX[W-1:0];
      if (s < WMIN) return WMIN[W-1:0];
      return s[W-1:0];
   endfunction

   function automatic logic signed [OPERAND_W-1:0] ext_s(input word_type x);
      return {{(OPERAND_W-W){x[W-1]}}, x};
   endfunction

   // ------------------------------------------------------------------
   // Handshake: the pipeline moves as one; stall only on a held result
   // ------------------------------------------------------------------
   logic               adv;
   logic [LATENCY-1:0] vld_ff;

   assign rsp_tvalid = vld_ff[LATENCY-1];
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_tvalid};
      end
   end

   // ------------------------------------------------------------------
   // Kick registers
   // ------------------------------------------------------------------
   word_type ek_ff, bk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ek_ff <= '0;
         bk_ff <= '0;
      end else if (csr_we) begin
         if (csr_addr == CSR_ELECTRIC_KICK) ek_ff <= csr_wdata;
         if (csr_addr == CSR_MAGNETIC_KICK) bk_ff <= csr_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Unpack the transfer
   // ------------------------------------------------------------------
   vec_type req_mom, req_ef, req_bf;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         req_mom[i] = req_tdata[i*W +: W];
         req_ef[i]  = req_tdata[(3+i)*W +: W];
         req_bf[i]  = req_tdata[(6+i)*W +: W];
      end
   end

   // ------------------------------------------------------------------
   // Arithmetic stages
   // ------------------------------------------------------------------
   vec_type eh_w, bm_w, tv_w, r1_m1_w, r1_m2_w, sv_w, r2_m1_w, r2_m2_w;
   logic [2:0][63:0] sq_um_w, sq_tv_w, sq_nu_w;
   logic [32:0] g1_w, g2_w;

   vec_type mom_dly_ff [1:MOM_DLY];
   vec_type bm_dly_ff  [1:BM_DLY];
   vec_type um_dly_ff  [1:UM_DLY];
   vec_type tv_dly_ff  [1:TV_DLY];
   vec_type up_dly_ff  [1:UP_DLY];
   vec_type eh_dly_ff  [1:EH_DLY];
   vec_type nu_dly_ff  [1:NU_DLY];

   vec_type um_ff, r1_s_ff, r1_m2_ff, up_ff, r2_s_ff, r2_m2_ff, upl_ff, nu_ff;
   vec_type um_in, r1_s_in, up_in, r2_s_in, upl_in, nu_in;

   logic [63:0] div_d_ff   [0:DIV_STEPS];
   logic [63:0] div_rem_ff [0:DIV_STEPS];
   logic [33:0] div_q_ff   [0:DIV_STEPS];

   vec_type     rsp_mom_ff;
   logic [32:0] rsp_gam_ff;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      // half electric kick and magnetic kick times field
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(KICK_FRAC)) u_eh (
         .clock(clock), .en(adv), .a_i(ext_s(ek_ff)), .b_i(ext_s(req_ef[i])),
         .prod_o(eh_w[i]), .sq_o());
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(KICK_FRAC)) u_bm (
         .clock(clock), .en(adv), .a_i(ext_s(bk_ff)), .b_i(ext_s(req_bf[i])),
         .prod_o(bm_w[i]), .sq_o());

      // squares of u-
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(FRAC)) u_sq_um (
         .clock(clock), .en(adv), .a_i(ext_s(um_ff[i])), .b_i(ext_s(um_ff[i])),
         .prod_o(), .sq_o(sq_um_w[i]));

      // T = kick*B scaled by 1/gamma
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(FRAC)) u_tv (
         .clock(clock), .en(adv), .a_i(ext_s(bm_dly_ff[BM_DLY][i])),
         .b_i({{(OPERAND_W-33){1'b0}}, g1_w}), .prod_o(tv_w[i]), .sq_o());

      // first rotation cross products
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(FRAC)) u_r1_m1 (
         .clock(clock), .en(adv), .a_i(ext_s(um_dly_ff[UM_TAP1][J])), .b_i(ext_s(tv_w[K])),
         .prod_o(r1_m1_w[i]), .sq_o());
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(FRAC)) u_r1_m2 (
         .clock(clock), .en(adv), .a_i(ext_s(um_dly_ff[UM_TAP1][K])), .b_i(ext_s(tv_w[J])),
         .prod_o(r1_m2_w[i]), .sq_o());

      // squares of T
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(FRAC)) u_sq_tv (
         .clock(clock), .en(adv), .a_i(ext_s(tv_w[i])), .b_i(ext_s(tv_w[i])),
         .prod_o(), .sq_o(sq_tv_w[i]));

      // S = T * 2/(1+|T|^2)
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(FRAC)) u_sv (
         .clock(clock), .en(adv), .a_i({{(OPERAND_W-34){1'b0}}, div_q_ff[DIV_STEPS]}),
         .b_i(ext_s(tv_dly_ff[TV_DLY][i])), .prod_o(sv_w[i]), .sq_o());

      // second rotation cross products
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(FRAC)) u_r2_m1 (
         .clock(clock), .en(adv), .a_i(ext_s(up_dly_ff[UP_DLY][J])), .b_i(ext_s(sv_w[K])),
         .prod_o(r2_m1_w[i]), .sq_o());
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(FRAC)) u_r2_m2 (
         .clock(clock), .en(adv), .a_i(ext_s(up_dly_ff[UP_DLY][K])), .b_i(ext_s(sv_w[J])),
         .prod_o(r2_m2_w[i]), .sq_o());

      // squares of the new momentum
      bmp_mul #(.DATA_WIDTH(W), .SHIFT(FRAC)) u_sq_nu (
         .clock(clock), .en(adv), .a_i(ext_s(nu_ff[i])), .b_i(ext_s(nu_ff[i])),
         .prod_o(), .sq_o(sq_nu_w[i]));
   end

   bmp_isqrt u_isqrt_g1 (.clock(clock), .en(adv), .t_i(sq_um_w), .r_o(g1_w));
   bmp_isqrt u_isqrt_g2 (.clock(clock), .en(adv), .t_i(sq_nu_w), .r_o(g2_w));

   // saturating sums: kick, both rotations (add then subtract), second kick
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         um_in[i]   = sat_sum(mom_dly_ff[MOM_DLY][i], eh_w[i], 1'b0);
         r1_s_in[i] = sat_sum(um_dly_ff[UM_TAP2][i], r1_m1_w[i], 1'b0);
         up_in[i]   = sat_sum(r1_s_ff[i], r1_m2_ff[i], 1'b1);
         r2_s_in[i] = sat_sum(um_dly_ff[UM_DLY][i], r2_m1_w[i], 1'b0);
         upl_in[i]  = sat_sum(r2_s_ff[i], r2_m2_ff[i], 1'b1);
         nu_in[i]   = sat_sum(upl_ff[i], eh_dly_ff[EH_DLY][i], 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         um_ff    <= um_in;
         r1_s_ff  <= r1_s_in;
         r1_m2_ff <= r1_m2_w;
         up_ff    <= up_in;
         r2_s_ff  <= r2_s_in;
         r2_m2_ff <= r2_m2_w;
         upl_ff   <= upl_in;
         nu_ff    <= nu_in;
      end
   end

   // alignment lines: hold each operand until its partner arrives
   always_ff @(posedge clock) begin
      if (adv) begin
         mom_dly_ff[1] <= req_mom;
         bm_dly_ff[1]  <= bm_w;
         um_dly_ff[1]  <= um_ff;
         tv_dly_ff[1]  <= tv_w;
         up_dly_ff[1]  <= up_ff;
         eh_dly_ff[1]  <= eh_w;
         nu_dly_ff[1]  <= nu_ff;
         for (int k = 2; k <= MOM_DLY; k++) mom_dly_ff[k] <= mom_dly_ff[k-1];
         for (int k = 2; k <= BM_DLY; k++)  bm_dly_ff[k]  <= bm_dly_ff[k-1];
         for (int k = 2; k <= UM_DLY; k++)  um_dly_ff[k]  <= um_dly_ff[k-1];
         for (int k = 2; k <= TV_DLY; k++)  tv_dly_ff[k]  <= tv_dly_ff[k-1];
         for (int k = 2; k <= UP_DLY; k++)  up_dly_ff[k]  <= up_dly_ff[k-1];
         for (int k = 2; k <= EH_DLY; k++)  eh_dly_ff[k]  <= eh_dly_ff[k-1];
         for (int k = 2; k <= NU_DLY; k++)  nu_dly_ff[k]  <= nu_dly_ff[k-1];
      end
   end

   // ------------------------------------------------------------------
   // 2/(1+|T|^2): restoring division of 2^65, one quotient bit a stage.
   // The top 32 quotient bits are always zero since the divisor is >= 1.0,
   // so start with the remainder left after them.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         div_d_ff[0]   <= norm_sum(sq_tv_w[0], sq_tv_w[1], sq_tv_w[2]);
         div_rem_ff[0] <= 64'h0000_0000_8000_0000;
         div_q_ff[0]   <= '0;
      end
   end

   for (genvar n = 0; n < DIV_STEPS; n++) begin : g_div
      localparam int B = DIV_STEPS - 1 - n;
      logic [64:0] shl;
      logic [64:0] diff;
      logic        ge;

      assign shl  = {div_rem_ff[n], 1'b0};
      assign diff = shl - {1'b0, div_d_ff[n]};
      assign ge   = (shl >= {1'b0, div_d_ff[n]});

      always_ff @(posedge clock) begin
         if (adv) begin
            div_d_ff[n+1]   <= div_d_ff[n];
            div_rem_ff[n+1] <= ge ? diff[63:0] : shl[63:0];
            div_q_ff[n+1]   <= div_q_ff[n] | ({33'd0, ge} << B);
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_mom_ff <= nu_dly_ff[NU_DLY];
         rsp_gam_ff <= g2_w;
      end
   end

   assign rsp_tdata = RSP_TDATA_W'({rsp_gam_ff, rsp_mom_ff[2], rsp_mom_ff[1], rsp_mom_ff[0]});

endmodule

`default_nettype wire

// ===== rtl/bmp_checker.sv =====
`default_nettype none

module bmp_checker #(
   parameter int DATA_WIDTH = 48,
   localparam int RSP_TDATA_W = ((3 * DATA_WIDTH + 33 + 7) / 8) * 8
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int G_LO = 3 * DATA_WIDTH;
   localparam int G_HI = G_LO + 32;

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // 1/gamma never exceeds 1.0
   a_gamma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[G_HI] && (|rsp_tdata[G_HI-1:G_LO])))
      else $error("inverse gamma above one");

   // with no result waiting the input side must be open
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind boris_momentum_push_core bmp_checker #(.DATA_WIDTH(DATA_WIDTH)) u_bmp_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

`default_nettype wire

// ===== sim/boris_momentum_push_core_tb.sv =====
`default_nettype none

module boris_momentum_push_core_tb;
   import bmp_pkg::*;

   localparam int DW          = 48;
   localparam int REQ_W       = ((9 * DW + 7) / 8) * 8;
   localparam int RSP_W       = ((3 * DW + 33 + 7) / 8) * 8;
   localparam int RAND_ITEMS  = 270;     // per kick setting, five settings
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 300;     // comfortably beyond the pipeline latency
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [127:0] W_MAX = (128'sd1 <<< (DW - 1)) - 1;
   localparam logic signed [127:0] W_MIN = -(128'sd1 <<< (DW - 1));

   typedef logic signed [63:0] wide_t;
   typedef logic [DW-1:0] field_t;

   typedef struct {
      field_t      mom[3];
      logic [32:0] gamma_recip;
   } push_result_t;

   // ---------------------------------------------------------------- push arithmetic
   // exact product, round half up after dropping sh bits, clamp to the data width
   function automatic wide_t mul_round(wide_t a, wide_t b, int sh);
      logic signed [127:0] p, q;
      p = 128'(a);
      q = 128'(b);
      p = p * q;
      p = (p + (128'sd1 <<< (sh - 1))) >>> sh;
      if (p > W_MAX) p = W_MAX;
      if (p < W_MIN) p = W_MIN;
      return wide_t'(p);
   endfunction

   function automatic wide_t add_clamp(wide_t a, wide_t b);
      wide_t s;
      s = a + b;
      if (s > wide_t'(W_MAX)) s = wide_t'(W_MAX);
      if (s < wide_t'(W_MIN)) s = wide_t'(W_MIN);
      return s;
   endfunction

   function automatic wide_t widen(field_t f);
      return wide_t'($signed(f));
   endfunction

   // 1 + |v|^2 in unsigned Q.32, clamped at all ones
   function automatic logic [63:0] one_plus_sq(wide_t v[3]);
      logic [65:0]  acc;
      logic [127:0] sq;
      logic [63:0]  m;
      acc = {2'b00, ONE_Q32};
      for (int i = 0; i < 3; i++) begin
         m   = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
         sq  = {64'd0, m};
         sq  = sq * sq;
         acc = acc + ((sq[127:96] != 0) ? {2'b00, 64'hFFFF_FFFF_FFFF_FFFF}
                                         : {2'b00, sq[95:32]});
         if (acc[65:64] != 0) acc = {2'b00, 64'hFFFF_FFFF_FFFF_FFFF};
      end
      return acc[63:0];
   endfunction

   // largest r with r*r*g <= 2^96
   function automatic logic [63:0] inv_root(logic [63:0] g);
      logic [63:0]  r, c;
      logic [127:0] p;
      r = '0;
      if (g <= ONE_Q32) return ONE_Q32;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         p = {64'd0, c};
         p = p * p;
         p = p * {64'd0, g};
         if (p <= (128'd1 << 96)) r = c;
      end
      return r;
   endfunction

   function automatic wide_t cross_add(wide_t base, wide_t pj, wide_t qk, wide_t pk, wide_t qj);
      wide_t s;
      s = add_clamp(base, mul_round(pj, qk, FRAC));
      return add_clamp(s, -mul_round(pk, qj, FRAC));
   endfunction

   // ---------------------------------------------------------------- scoreboard
   class push_scoreboard;
      field_t       electric_kick = '0, magnetic_kick = '0;
      push_result_t pending_q[$];
      int           mismatches, checked;

      function void set_kick(logic [CSR_ADDR_W-1:0] idx, field_t val);
         if (idx == CSR_ELECTRIC_KICK) electric_kick = val;
         else if (idx == CSR_MAGNETIC_KICK) magnetic_kick = val;
      endfunction

      function void note_particle(logic [REQ_W-1:0] d);
         wide_t        mom[3], ef[3], bf[3], eh[3], um[3], tv[3], up[3], sv[3], nu[3];
         logic [63:0]  g1, tf;
         logic [65:0]  num;
         push_result_t r;
         for (int i = 0; i < 3; i++) begin
            mom[i] = widen(d[DW*i +: DW]);
            ef[i]  = widen(d[DW*(3+i) +: DW]);
            bf[i]  = widen(d[DW*(6+i) +: DW]);
         end
         for (int i = 0; i < 3; i++) begin
            eh[i] = mul_round(widen(electric_kick), ef[i], KICK_FRAC);
            um[i] = add_clamp(mom[i], eh[i]);
         end
         g1 = inv_root(one_plus_sq(um));
         for (int i = 0; i < 3; i++)
            tv[i] = mul_round(mul_round(widen(magnetic_kick), bf[i], KICK_FRAC),
                              wide_t'(g1), FRAC);
         for (int i = 0; i < 3; i++)
            up[i] = cross_add(um[i], um[(i+1)%3], tv[(i+2)%3], um[(i+2)%3], tv[(i+1)%3]);
         num = 66'd1 << 65;
         tf  = 64'(num / {2'b00, one_plus_sq(tv)});
         for (int i = 0; i < 3; i++)
            sv[i] = mul_round(wide_t'(tf), tv[i], FRAC);
         for (int i = 0; i < 3; i++) begin
            nu[i] = cross_add(um[i], up[(i+1)%3], sv[(i+2)%3], up[(i+2)%3], sv[(i+1)%3]);
            nu[i] = add_clamp(nu[i], eh[i]);
            r.mom[i] = field_t'(nu[i]);
         end
         r.gamma_recip = 33'(inv_root(one_plus_sq(nu)));
         pending_q.push_back(r);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_result(logic [RSP_W-1:0] d);
         push_result_t e;
         if (pending_q.size() == 0) begin
            report("result with nothing outstanding");
            return;
         end
         e = pending_q.pop_front();
         checked++;
         for (int i = 0; i < 3; i++)
            if (d[DW*i +: DW] !== e.mom[i])
               report($sformatf("new_mom[%0d] got %h want %h", i, d[DW*i +: DW], e.mom[i]));
         if (d[3*DW +: 33] !== e.gamma_recip)
            report($sformatf("inverse_gamma got %h want %h", d[3*DW +: 33], e.gamma_recip));
      endtask
   endclass

   // ---------------------------------------------------------------- harness
   logic                  clock, reset;
   logic                  req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_W-1:0]      req_tdata;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [DW-1:0]         csr_wdata;

   push_scoreboard sb;
   int  cycles;
   int  idle_pct;      // chance in a hundred that either side idles this cycle
   int  hold_off;      // receiver stall still to run, in cycles
   int  sent;

   boris_momentum_push_core #(.DATA_WIDTH(DW)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // monitor: sample both transfers at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_particle(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("boris_momentum_push_core test failed");
         $finish;
      end
   end

   // receiver: random back-pressure plus the occasional long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off   <= hold_off - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // random 48-bit field value, biased towards sizes a pusher really sees
   function automatic field_t rand_field();
      field_t v;
      int     w;
      case ($urandom_range(9))
         0:       v = {1'b0, {(DW-1){1'b1}}};
         1:       v = {1'b1, {(DW-1){1'b0}}};
         2:       v = '0;
         3, 4, 5: v = field_t'({$urandom, $urandom});
         default: begin
            // modest magnitude: sign-extend a short random value
            w = $urandom_range(44, 20);
            v = field_t'({$urandom, $urandom});
            v = field_t'($signed(v << (DW - w)) >>> (DW - w));
         end
      endcase
      return v;
   endfunction

   function automatic field_t rand_kick();
      field_t v;
      int     w;
      w = $urandom_range(44, 24);
      v = field_t'({$urandom, $urandom});
      return field_t'($signed(v << (DW - w)) >>> (DW - w));
   endfunction

   task write_csr(logic [CSR_ADDR_W-1:0] idx, field_t val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_kick(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // offer one particle; returns after its transfer
   task send_particle(field_t f[9]);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      for (int i = 0; i < 9; i++) req_tdata[DW*i +: DW] <= f[i];
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sent++;
   endtask

   task send_random();
      field_t f[9];
      for (int i = 0; i < 9; i++) f[i] = rand_field();
      send_particle(f);
   endtask

   // stop offering and wait until every outstanding result has come back
   task drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task directed_set();
      field_t f[9];
      field_t fmax, fmin;
      fmax = {1'b0, {(DW-1){1'b1}}};
      fmin = {1'b1, {(DW-1){1'b0}}};
      // all zero: momentum stays at rest and 1/gamma is exactly one
      foreach (f[i]) f[i] = '0;
      send_particle(f);
      // rest particle in strong fields
      for (int i = 3; i < 9; i++) f[i] = fmax;
      send_particle(f);
      for (int i = 3; i < 9; i++) f[i] = fmin;
      send_particle(f);
      // extreme everything, then extreme momenta in zero fields
      foreach (f[i]) f[i] = fmax;
      send_particle(f);
      foreach (f[i]) f[i] = fmin;
      send_particle(f);
      foreach (f[i]) f[i] = (i % 2) ? fmax : fmin;
      send_particle(f);
      foreach (f[i]) f[i] = (i < 3) ? fmax : '0;
      send_particle(f);
      // unit momentum along x in a unit field along z, then with a unit electric field along z too
      foreach (f[i]) f[i] = '0;
      f[0] = field_t'(ONE_Q32);
      f[8] = field_t'(ONE_Q32);
      send_particle(f);
      f[5] = field_t'(ONE_Q32);
      send_particle(f);
   endtask

   initial begin
      field_t kicks[5][2];
      sb         = new();
      cycles     = 0;
      sent       = 0;
      hold_off   = 0;
      idle_pct   = 9;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_ELECTRIC_KICK;
      csr_wdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      kicks[0] = '{'0, '0};
      kicks[1] = '{48'h0000_0028_F5C2, 48'h0000_0A3D_70A3};   // small, realistic
      kicks[2] = '{{1'b0, {(DW-1){1'b1}}}, {1'b0, {(DW-1){1'b1}}}};
      kicks[3] = '{{1'b1, {(DW-1){1'b0}}}, {1'b1, {(DW-1){1'b0}}}};
      kicks[4] = '{rand_kick(), rand_kick()};

      for (int ph = 0; ph < 5; ph++) begin
         write_csr(CSR_ELECTRIC_KICK, kicks[ph][0]);
         write_csr(CSR_MAGNETIC_KICK, kicks[ph][1]);
         // a write to an index that has no register must change nothing
         write_csr(CSR_UNUSED, field_t'({$urandom, $urandom}));
         if (ph == 0 || ph == 2 || ph == 3) directed_set();
         idle_pct = (ph == 3) ? 0 : 9;        // one stretch with no idling at all
         for (int n = 0; n < RAND_ITEMS; n++) begin
            if (ph == 1 && n == 40) hold_off = 600;   // fill the pipe and stall the input
            if (ph == 4 && n == 100) drain();         // sender pauses until all is back
            send_random();
         end
         drain();
      end

      $display("covered %0d particles over five kick settings (zero, small, both extremes,",
               sent);
      $display("random), with back-pressure, a long output stall and a full drain");
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("boris_momentum_push_core test passed");
      end else begin
         $display("boris_momentum_push_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
